/* design/rde_pkg.sv */
package rde_pkg;

  localparam int STORE_DEPTH_DEF = 32;

  localparam logic [31:0] RADIX_RST        = 32'd2;
  localparam logic [5:0]  POLY_LENGTH_RST  = 6'd20;
  localparam logic [5:0]  BLOCK_LENGTH_RST = 6'd1;

  localparam logic [1:0] ACT_EMBED   = 2'd0;
  localparam logic [1:0] ACT_WHOLE   = 2'd1;
  localparam logic [1:0] ACT_BLOCKS  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [1:0] REG_RADIX        = 2'd0;
  localparam logic [1:0] REG_POLY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] value;
    logic [4:0]  offset;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [5:0]  digits_written;
    logic        overflow;
  } out_req_t;

endpackage

/* design/rde_store.sv */
module rde_store import rde_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0]            mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [31:0]            rd_raw;
  logic                   rd_ok;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_ok <= rd_en && written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_raw : 32'd0;

endmodule

/* design/radix_digit_embed_extract.sv */
// Embed: each digit takes a check, a bit-serial division by the radix
// (one quotient bit a cycle over 64 bits) and a write to the store.
// Extract: each block position takes a check, a check and a read per
// summed coefficient through the one-read-per-cycle store port, the
// two-pass 32x32 multiply and an add. One request is worked on at a time;
// a finished result waits in an output register. Synchronous active-high
// reset clears the store and registers.
module radix_digit_embed_extract import rde_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  // Wide enough for an embed position (offset plus up to 64 digits) and for
  // an extract address (block base plus position, both below 64).
  localparam int POS_W = $clog2(STORE_DEPTH + 128);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ECHK = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_DWR  = 4'd3;
  localparam logic [3:0] S_JCHK = 4'd4;
  localparam logic [3:0] S_SCHK = 4'd5;
  localparam logic [3:0] S_SRD  = 4'd6;
  localparam logic [3:0] S_MLO  = 4'd7;
  localparam logic [3:0] S_MHI  = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  // Configuration registers. Writes land at any time; the port never waits.
  logic [31:0] radix;
  logic [5:0]  poly_length;
  logic [5:0]  block_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RST;
      poly_length  <= POLY_LENGTH_RST;
      block_length <= BLOCK_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:        radix        <= cfg_data;
        REG_POLY_LENGTH:  poly_length  <= cfg_data[5:0];
        REG_BLOCK_LENGTH: block_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // A radix of 0 or 1 behaves as 2.
  logic [31:0] r_eff;
  assign r_eff = (radix < 32'd2) ? 32'd2 : radix;

  logic [3:0]       state;
  logic [63:0]      quo;       // value still to split; quotient while dividing
  logic [31:0]      rem;
  logic [6:0]       bit_cnt;
  logic [POS_W-1:0] pos;
  logic [5:0]       ndig;
  logic             lost;
  logic [63:0]      acc;
  logic [63:0]      psum;      // sum over blocks for the current position
  logic [63:0]      prod_lo;
  logic [31:0]      prod_hi;
  logic [5:0]       blen;      // positions per block for this request
  logic [5:0]       jpos;      // positions left; current position is jpos - 1
  logic [POS_W-1:0] base;

  // One step of restoring division by the radix.
  logic [32:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, quo[63]};
  assign q_bit  = rem_sh >= {1'b0, r_eff};

  // Shared 32x32 multiplier: low half of acc first, then high half.
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  assign mul_a = (state == S_MLO) ? acc[31:0] : acc[63:32];
  assign mul_p = {32'd0, mul_a} * {32'd0, r_eff};

  // Block k is complete when base + blen does not pass poly_length.
  logic [POS_W-1:0] rd_pos;
  logic             blk_ok;
  assign rd_pos = base + POS_W'(jpos - 6'd1);
  assign blk_ok = (base + POS_W'(blen)) <= POS_W'(poly_length);

  logic          st_wr_en;
  logic          st_rd_en;
  logic [31:0]   st_rd_data;

  assign st_wr_en = (state == S_DWR) && (pos < POS_W'(STORE_DEPTH));
  assign st_rd_en = (state == S_SCHK) && blk_ok && (rd_pos < POS_W'(STORE_DEPTH));

  rde_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (st_wr_en),
    .wr_addr (pos[AW-1:0]),
    .wr_data (rem),
    .rd_en   (st_rd_en),
    .rd_addr (rd_pos[AW-1:0]),
    .rd_data (st_rd_data)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The finish state loads the output register itself.
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            quo  <= in_data.value;
            pos  <= POS_W'(in_data.offset);
            ndig <= 6'd0;
            lost <= 1'b0;
            acc  <= 64'd0;
            case (in_data.action)
              ACT_EMBED: begin
                state <= S_ECHK;
              end
              ACT_WHOLE: begin
                // The whole polynomial is a single block of poly_length.
                blen  <= poly_length;
                jpos  <= poly_length;
                state <= S_JCHK;
              end
              ACT_BLOCKS: begin
                blen  <= (block_length == 6'd0) ? 6'd1 : block_length;
                jpos  <= (block_length == 6'd0) ? 6'd1 : block_length;
                state <= S_JCHK;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_ECHK: begin
          if (quo == 64'd0) begin
            state <= S_FIN;
          end else begin
            rem     <= 32'd0;
            bit_cnt <= 7'd64;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= q_bit ? 32'(rem_sh - {1'b0, r_eff}) : rem_sh[31:0];
          quo     <= {quo[62:0], q_bit};
          bit_cnt <= bit_cnt - 7'd1;
          if (bit_cnt == 7'd1) begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          // The digit in rem is stored this cycle when the position exists.
          if (pos < POS_W'(STORE_DEPTH)) begin
            if (ndig != 6'd63) begin
              ndig <= ndig + 6'd1;
            end
          end else begin
            lost <= 1'b1;
          end
          pos   <= pos + POS_W'(1);
          state <= S_ECHK;
        end
        S_JCHK: begin
          if (jpos == 6'd0) begin
            state <= S_FIN;
          end else begin
            base  <= '0;
            psum  <= 64'd0;
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          state <= blk_ok ? S_SRD : S_MLO;
        end
        S_SRD: begin
          psum  <= psum + 64'(st_rd_data);
          base  <= base + POS_W'(blen);
          state <= S_SCHK;
        end
        S_MLO: begin
          prod_lo <= mul_p;
          state   <= S_MHI;
        end
        S_MHI: begin
          prod_hi <= mul_p[31:0];
          state   <= S_ADD;
        end
        S_ADD: begin
          acc   <= prod_lo + {prod_hi, 32'd0} + psum;
          jpos  <= jpos - 6'd1;
          state <= S_JCHK;
        end
        S_FIN: begin
          // Hold here until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.result_value   <= acc;
            out_data.digits_written <= ndig;
            out_data.overflow       <= lost;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/rde_checker.sv */
module rde_checker import rde_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data,
  input logic     cfg_ready
);

  // A stalled result stays presented and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // One request at a time: after an accept the input waits.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // A result cannot appear in the cycle right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind radix_digit_embed_extract rde_checker u_rde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

/* verif/radix_digit_embed_extract_tb.sv */
`timescale 1ns / 1ps

// Checks the radix digit embed / extract block against an in-bench model of
// its coefficient store. Every accepted request is mirrored in the model at
// the moment it is accepted. The expected result goes into a queue, and a
// checker pops that queue for each result the block hands back. Sender and
// receiver both idle at random. One test holds the receiver off long enough
// to back the block up.
module radix_digit_embed_extract_tb;
  import rde_pkg::*;

  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 20000;  // well above the longest embed
  localparam int TAIL_CYCLES = 200;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  radix_digit_embed_extract dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block's state: the coefficient store and the three registers.
  logic [31:0] coeff_mirror [DEPTH];
  logic [31:0] radix_reg;
  logic [5:0]  length_reg;
  logic [5:0]  block_reg;

  out_req_t pending_results [$];
  int mismatches;
  int rx_hold;        // a long receiver hold-off, consumed by the receiver
  bit rx_busy_mode;   // when clear, the receiver never stalls
  bit tx_busy_mode;   // when clear, the sender sends back to back

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] effective_radix();
    return (radix_reg < 32'd2) ? 64'd2 : {32'd0, radix_reg};
  endfunction

  function automatic logic [63:0] coeff_at(int pos);
    return (pos < DEPTH) ? {32'd0, coeff_mirror[pos]} : 64'd0;
  endfunction

  // Works out the result of one request and applies any store update it makes.
  function automatic out_req_t apply_request(in_req_t req);
    out_req_t    res;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] lane_sum [64];
    int pos;
    int count;
    int bl;
    int nblocks;
    res = '0;
    r = effective_radix();
    acc = 64'd0;
    case (req.action)
      ACT_EMBED: begin
        // Lowest digit first; digits that land past the store are dropped.
        v = req.value;
        pos = req.offset;
        count = 0;
        while (v != 64'd0) begin
          if (pos < DEPTH) begin
            coeff_mirror[pos] = 32'(v % r);
            if (count < 63) count++;
          end else begin
            res.overflow = 1'b1;
          end
          pos++;
          v = v / r;
        end
        res.digits_written = 6'(count);
      end
      ACT_WHOLE: begin
        for (int i = int'(length_reg) - 1; i >= 0; i--)
          acc = acc * r + coeff_at(i);
        res.result_value = acc;
      end
      ACT_BLOCKS: begin
        // A block length of zero counts as one; a partial trailing block is ignored.
        bl = (block_reg == 6'd0) ? 1 : int'(block_reg);
        nblocks = int'(length_reg) / bl;
        for (int j = 0; j < bl; j++) begin
          lane_sum[j] = 64'd0;
          for (int k = 0; k < nblocks; k++)
            lane_sum[j] += coeff_at(k * bl + j);
        end
        for (int j = bl - 1; j >= 0; j--)
          acc = acc * r + lane_sum[j];
        res.result_value = acc;
      end
      default: ;  // The unused action leaves everything at zero.
    endcase
    return res;
  endfunction

  // Sends one request, after a random gap unless the sender runs flat out.
  task automatic send_request(logic [1:0] action, logic [63:0] value, logic [4:0] offset);
    in_req_t req;
    int gap;
    req.action = action;
    req.value = value;
    req.offset = offset;
    gap = tx_busy_mode ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(req));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Every request yields a result, but give the block a moment anyway.
    repeat (10) @(negedge clk);
  endtask

  // Registers are written only with the block idle.
  task automatic write_register(logic [1:0] index, logic [31:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_RADIX:        radix_reg = data;
      REG_POLY_LENGTH:  length_reg = data[5:0];
      REG_BLOCK_LENGTH: block_reg = data[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] radix, logic [31:0] len, logic [31:0] blk);
    write_register(REG_RADIX, radix);
    write_register(REG_POLY_LENGTH, len);
    write_register(REG_BLOCK_LENGTH, blk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    // Shift down by a random amount so short and long digit strings both show up.
    return ($urandom_range(0, 3) == 0) ? v : (v >> $urandom_range(0, 63));
  endfunction

  // The store starts at zero and the registers at their reset values.
  task automatic test_reset_state();
    send_request(ACT_WHOLE, 64'd0, 5'd0);
    send_request(ACT_BLOCKS, 64'd0, 5'd0);
  endtask

  // Embed edge cases at the reset radix of two, followed by both extractions.
  task automatic test_embed_edges();
    send_request(ACT_EMBED, 64'd0, 5'd0);                  // zero value writes nothing
    send_request(ACT_EMBED, '1, 5'd0);                      // 64 digits, half dropped
    send_request(ACT_WHOLE, 64'd0, 5'd0);
    send_request(ACT_EMBED, 64'h8000_0000_0000_0001, 5'd31); // nearly all dropped
    send_request(ACT_EMBED, 64'd5, 5'd3);
    send_request(ACT_NONE, '1, 5'd31);                       // unused action
    send_request(ACT_BLOCKS, '1, 5'd7);
    send_request(ACT_WHOLE, 64'd0, 5'd0);
  endtask

  // Register extremes: radix below two, the widest radix, zero and oversize lengths.
  task automatic test_config_extremes();
    set_config(32'd0, 32'd32, 32'd0);
    send_request(ACT_EMBED, 64'hDEAD_BEEF_0123_4567, 5'd0);
    send_request(ACT_BLOCKS, 64'd0, 5'd0);
    set_config(32'd1, 32'd63, 32'd63);     // length past the store, block as long as length
    send_request(ACT_WHOLE, 64'd0, 5'd0);
    send_request(ACT_BLOCKS, 64'd0, 5'd0);
    set_config('1, 32'd0, 32'd32);         // zero length
    send_request(ACT_EMBED, '1, 5'd30);
    send_request(ACT_WHOLE, 64'd0, 5'd0);
    send_request(ACT_BLOCKS, 64'd0, 5'd0);
    set_config('1, 32'd32, 32'd1);
    send_request(ACT_EMBED, '1, 5'd0);
    send_request(ACT_WHOLE, 64'd0, 5'd0);
    send_request(ACT_BLOCKS, 64'd0, 5'd0);
  endtask

  function automatic logic [1:0] random_action();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return ACT_EMBED;
    if (pick < 15) return ACT_WHOLE;
    if (pick < 19) return ACT_BLOCKS;
    return ACT_NONE;
  endfunction

  task automatic send_random_request();
    logic [4:0] off;
    off = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    send_request(random_action(), random_value(), off);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills up and has to stall its input.
  task automatic test_backpressure();
    set_config(32'd1000, 32'd12, 32'd4);
    tx_busy_mode = 1'b0;
    rx_hold = 400;
    repeat (8) send_random_request();
    tx_busy_mode = 1'b1;
    // The sender then waits until every result is back before going on.
    wait_drained();
    repeat (6) send_random_request();
  endtask

  task automatic test_random();
    logic [31:0] radix_pick;
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 7))
        0: radix_pick = 32'd2;
        1: radix_pick = 32'd3;
        2: radix_pick = 32'd10;
        3: radix_pick = 32'd16;
        4: radix_pick = 32'd256;
        5: radix_pick = 32'($urandom_range(0, 1));
        6: radix_pick = '1;
        default: radix_pick = $urandom();
      endcase
      set_config(radix_pick, $urandom_range(0, 63), $urandom_range(0, 63));
      // One phase runs with no idling on either side.
      rx_busy_mode = (phase != 4);
      tx_busy_mode = (phase != 4);
      repeat (48) send_random_request();
    end
    rx_busy_mode = 1'b1;
    tx_busy_mode = 1'b1;
  endtask

  // Receiver: draws a hold-off per result, takes one, and starts again.
  initial begin : receiver
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      n = rx_busy_mode ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_req_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value
            || out_data.digits_written !== want.digits_written
            || out_data.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected value %h digits %0d ovf %b, got value %h digits %0d ovf %b",
                     $realtime, want.result_value, want.digits_written, want.overflow,
                     out_data.result_value, out_data.digits_written, out_data.overflow);
        end
      end
    end
  end

  // Watchdog: a run with no handshake of any kind for too long has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : main
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RADIX;
    cfg_data = '0;
    mismatches = 0;
    rx_hold = 0;
    rx_busy_mode = 1'b1;
    tx_busy_mode = 1'b1;
    for (int i = 0; i < DEPTH; i++) coeff_mirror[i] = 32'd0;
    radix_reg = RADIX_RST;
    length_reg = POLY_LENGTH_RST;
    block_reg = BLOCK_LENGTH_RST;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_embed_edges();
    test_config_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
